[src/tree_noise_counter_release_unit_defines.svh]
// ----------------------------------------------------------------------------
// Tree noise counter release unit: assertion macros
// Concurrent check wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef TREE_NOISE_COUNTER_RELEASE_UNIT_DEFINES_SVH
`define TREE_NOISE_COUNTER_RELEASE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define TNCR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tncr check failed");
// condition must never be true out of reset
`define TNCR_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tncr forbidden condition");
`else
`define TNCR_ASSERT(label, clk, rst_n, prop)
`define TNCR_NEVER(label, clk, rst_n, cond)
`endif

`endif

[src/tncr_pkg.sv]
// ----------------------------------------------------------------------------
// tncr_pkg
// Shared widths and parameter defaults of the tree noise counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tncr_pkg;
	localparam int VALUE_W           = 44;
	localparam int NOISE_W           = 24;
	localparam int OUT_W             = 47;
	localparam int EPS_W             = 32;
	localparam int DATA_W            = 64;
	localparam int INDEX_BITS_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 16;
endpackage

`default_nettype wire

[src/tncr_ram.sv]
// ----------------------------------------------------------------------------
// tncr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tncr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

[src/tncr_noise.sv]
// ----------------------------------------------------------------------------
// tncr_noise
// Scales a unit Laplace sample by mult * inverse epsilon (three stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tncr_noise
	import tncr_pkg::*;
#(
	parameter int LIM_W         = 5,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [LIM_W-1:0]         mult,
	input  wire logic [EPS_W-1:0]         inv_eps,
	input  wire logic [NOISE_W-1:0]       unit,
	output logic signed [DATA_W-1:0]      noise,
	output logic                          noise_vld
);
	localparam int SCALE_W = LIM_W + EPS_W;
	localparam int P_W     = NOISE_W + SCALE_W;

	logic [SCALE_W-1:0]           scale_s1;
	logic [NOISE_W-1:0]           mag_s1;
	logic                         neg_s1;
	logic                         vld_s1;
	logic [NOISE_W+EPS_W-1:0]     plo_s2;
	logic [NOISE_W+LIM_W-1:0]     phi_s2;
	logic                         neg_s2;
	logic                         vld_s2;
	logic [P_W-1:0]               psum;
	logic [DATA_W-1:0]            pmag;

	// magnitude times scale, truncated toward zero
	assign psum = P_W'(plo_s2) + (P_W'(phi_s2) << EPS_W);
	assign pmag = DATA_W'(psum >> FRACTION_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			noise_vld <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			if (start) begin
				noise_vld <= 1'b0;
			end else if (vld_s2) begin
				noise_vld <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			scale_s1 <= SCALE_W'(mult) * SCALE_W'(inv_eps);
			neg_s1   <= unit[NOISE_W-1];
			mag_s1   <= unit[NOISE_W-1] ? (~unit + NOISE_W'(1)) : unit;
		end
		plo_s2 <= (NOISE_W+EPS_W)'(mag_s1) * (NOISE_W+EPS_W)'(scale_s1[EPS_W-1:0]);
		phi_s2 <= (NOISE_W+LIM_W)'(mag_s1) * (NOISE_W+LIM_W)'(scale_s1[SCALE_W-1:EPS_W]);
		neg_s2 <= neg_s1;
		if (vld_s2) begin
			noise <= neg_s2 ? -$signed(pmag) : $signed(pmag);
		end
	end
endmodule

`default_nettype wire

[src/tree_noise_counter_release_unit.sv]
// ----------------------------------------------------------------------------
// Tree noise counter release unit (binary-tree continual release, Q fixed point)
// Sequence: restart in IDLE; power-of-two index BASE1, BASE2, FINAL; other index
//   WALK1, STORE, WALK2, FINAL, each walk over L = top bit length - 1 entries.
// Requests: one at a time; the two walks over the difference RAMs (one read
//   port each) bound the rate. Result waits in an output reg.
// Reset: arst_n clears index, bases, last release, scale to 1.0; RAMs unset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tree_noise_counter_release_unit_defines.svh"

module tree_noise_counter_release_unit
	import tncr_pkg::*;
#(
	parameter int INDEX_BITS    = INDEX_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration: inverse epsilon, unsigned Q.FRACTION_BITS
	input  wire logic                      cfg_wr_en,
	input  wire logic [EPS_W-1:0]          cfg_wr_data,
	// request channel
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      req_type,
	input  wire logic [VALUE_W-1:0]        raw_value,
	input  wire logic signed [NOISE_W-1:0] unit_noise_q16,
	// release channel
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [OUT_W-1:0]               noisy_value
);
	localparam int LIM_W = $clog2(INDEX_BITS);
	localparam int TBL_W = $clog2(INDEX_BITS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_BASE1,   // base += to_q(value - true base)
		S_BASE2,   // base += noise
		S_WALK1,   // find lowest set bit, subtract higher true differences
		S_STORE,   // write new difference entry
		S_WALK2,   // sum noisy differences onto the base
		S_FINAL    // clamp, monotone hold, load output
	} state_t;

	state_t                    state_q;
	logic [EPS_W-1:0]          inv_eps_q;
	logic [INDEX_BITS-1:0]     qi_q;
	logic [TBL_W-1:0]          tbl_q;
	logic [VALUE_W-1:0]        tb_q;
	logic [VALUE_W-1:0]        val_q;
	logic signed [DATA_W-1:0]  nb_q;
	logic signed [DATA_W-1:0]  acc_q;   // value - base - higher differences
	logic signed [DATA_W-1:0]  vq_q;    // running noisy sum
	logic [OUT_W-1:0]          lr_q;
	logic [LIM_W-1:0]          lim_q;
	logic [LIM_W-1:0]          cnt_q;   // walk read address
	logic                      pend_v_q;
	logic                      pend_set_q;
	logic [LIM_W-1:0]          pend_i_q;
	logic                      lsb_found_q;
	logic [LIM_W-1:0]          lsb_q;
	logic                      out_valid_q;
	logic [OUT_W-1:0]          noisy_q;

	logic                      accept;
	logic                      noise_start;
	logic [INDEX_BITS-1:0]     idx_nxt;
	logic                      is_pow2;
	logic [LIM_W-1:0]          pos;
	logic [LIM_W-1:0]          lim_cur;
	logic [LIM_W-1:0]          mult;
	logic signed [DATA_W-1:0]  noise;
	logic                      noise_vld;
	logic signed [DATA_W-1:0]  opa;
	logic signed [DATA_W-1:0]  opb;
	logic signed [DATA_W-1:0]  sat_res;
	logic signed [DATA_W-1:0]  nd_wdata;
	logic [DATA_W-1:0]         td_rdata;
	logic signed [DATA_W-1:0]  nd_rdata;
	logic                      ram_we;
	logic                      walk_done;
	logic                      fin_go;
	logic [DATA_W-1:0]         vq_shift;
	logic [OUT_W-1:0]          cand;
	logic [OUT_W-1:0]          rel;

	// signed add clamped to the 64-bit range
	function automatic logic signed [DATA_W-1:0] sat_add(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		logic signed [DATA_W-1:0] s;
		s = a + b;
		if (a[DATA_W-1] == b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1]) begin
			s = a[DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end
		return s;
	endfunction

	// integer to Q form, clamped when the shift overflows
	function automatic logic signed [DATA_W-1:0] to_q(input logic signed [DATA_W-1:0] d);
		logic [FRACTION_BITS:0]   hi;
		logic signed [DATA_W-1:0] r;
		hi = d[DATA_W-1 -: FRACTION_BITS+1];
		if (hi == '0 || hi == '1) begin
			r = d <<< FRACTION_BITS;
		end else if (d[DATA_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign noise_start = accept && !req_type;
	assign out_valid   = out_valid_q;
	assign noisy_value = noisy_q;

	// next index and its top bit when it is a power of two
	assign idx_nxt = qi_q + INDEX_BITS'(1);
	assign is_pow2 = (idx_nxt != '0) && ((idx_nxt & (idx_nxt - INDEX_BITS'(1))) == '0);

	always_comb begin
		pos = '0;
		for (int i = 0; i < INDEX_BITS; i++) begin
			if (idx_nxt[i]) begin
				pos = pos | LIM_W'(i);
			end
		end
	end

	assign lim_cur = (tbl_q != '0) ? LIM_W'(tbl_q - TBL_W'(1)) : '0;
	assign mult    = is_pow2 ? LIM_W'(1) : lim_cur;

	tncr_noise #(
		.LIM_W         (LIM_W),
		.FRACTION_BITS (FRACTION_BITS)
	) u_noise (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (noise_start),
		.mult      (mult),
		.inv_eps   (inv_eps_q),
		.unit      (unit_noise_q16),
		.noise     (noise),
		.noise_vld (noise_vld)
	);

	// shared saturating adder, operands picked by the sequencer
	always_comb begin
		unique case (state_q)
			S_BASE1: begin
				opa = nb_q;
				opb = to_q(acc_q);
			end
			S_BASE2: begin
				opa = nb_q;
				opb = noise;
			end
			S_STORE: begin
				opa = noise;
				opb = to_q(acc_q);
			end
			default: begin
				opa = vq_q;
				opb = nd_rdata;
			end
		endcase
	end
	assign sat_res  = sat_add(opa, opb);
	assign nd_wdata = sat_res;

	assign ram_we = (state_q == S_STORE) && noise_vld && lsb_found_q;

	tncr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (INDEX_BITS)
	) u_td_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (lsb_q),
		.wdata (acc_q),
		.raddr (cnt_q),
		.rdata (td_rdata)
	);

	tncr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (INDEX_BITS)
	) u_nd_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (lsb_q),
		.wdata (nd_wdata),
		.raddr (cnt_q),
		.rdata (nd_rdata)
	);

	assign walk_done = (cnt_q == lim_q) && !pend_v_q;
	assign fin_go    = (state_q == S_FINAL) && (!out_valid_q || out_ready);

	// clamp to [0, 2^47-1] and hold monotone
	assign vq_shift = DATA_W'(vq_q) >> FRACTION_BITS;
	always_comb begin
		if (vq_q[DATA_W-1] || vq_q == '0) begin
			cand = '0;
		end else if (vq_shift[DATA_W-1:OUT_W] != '0) begin
			cand = '1;
		end else begin
			cand = vq_shift[OUT_W-1:0];
		end
	end
	assign rel = (cand > lr_q) ? cand : lr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_eps_q <= EPS_W'(1) << FRACTION_BITS;
		end else if (cfg_wr_en) begin
			inv_eps_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			qi_q        <= '0;
			tbl_q       <= '0;
			tb_q        <= '0;
			val_q       <= '0;
			nb_q        <= '0;
			acc_q       <= '0;
			vq_q        <= '0;
			lr_q        <= '0;
			lim_q       <= '0;
			cnt_q       <= '0;
			pend_v_q    <= 1'b0;
			pend_set_q  <= 1'b0;
			pend_i_q    <= '0;
			lsb_found_q <= 1'b0;
			lsb_q       <= '0;
			out_valid_q <= 1'b0;
			noisy_q     <= '0;
		end else begin
			// a result taken while a new one loads is replaced below
			if (out_valid_q && out_ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type) begin
							qi_q <= '0;
							tb_q <= '0;
							nb_q <= '0;
							lr_q <= '0;
						end else begin
							qi_q  <= idx_nxt;
							val_q <= raw_value;
							acc_q <= DATA_W'(raw_value) - DATA_W'(tb_q);
							if (is_pow2) begin
								tbl_q   <= TBL_W'(pos) + TBL_W'(1);
								state_q <= S_BASE1;
							end else begin
								lim_q       <= lim_cur;
								cnt_q       <= '0;
								pend_v_q    <= 1'b0;
								lsb_found_q <= 1'b0;
								state_q     <= S_WALK1;
							end
						end
					end
				end
				S_BASE1: begin
					nb_q    <= sat_res;
					tb_q    <= val_q;
					state_q <= S_BASE2;
				end
				S_BASE2: begin
					if (noise_vld) begin
						nb_q    <= sat_res;
						vq_q    <= sat_res;
						state_q <= S_FINAL;
					end
				end
				S_WALK1: begin
					if (cnt_q != lim_q) begin
						pend_v_q   <= 1'b1;
						pend_set_q <= qi_q[cnt_q];
						pend_i_q   <= cnt_q;
						cnt_q      <= cnt_q + LIM_W'(1);
					end else begin
						pend_v_q <= 1'b0;
					end
					if (pend_v_q && pend_set_q) begin
						if (!lsb_found_q) begin
							lsb_found_q <= 1'b1;
							lsb_q       <= pend_i_q;
						end else begin
							acc_q <= acc_q - td_rdata;
						end
					end
					if (walk_done) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (noise_vld) begin
						vq_q     <= nb_q;
						cnt_q    <= '0;
						pend_v_q <= 1'b0;
						state_q  <= S_WALK2;
					end
				end
				S_WALK2: begin
					if (cnt_q != lim_q) begin
						pend_v_q   <= 1'b1;
						pend_set_q <= qi_q[cnt_q];
						cnt_q      <= cnt_q + LIM_W'(1);
					end else begin
						pend_v_q <= 1'b0;
					end
					if (pend_v_q && pend_set_q) begin
						vq_q <= sat_res;
					end
					if (walk_done) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						noisy_q     <= rel;
						lr_q        <= rel;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// release floor only drops on a restart
	`TNCR_ASSERT(a_lr_mono, clk, arst_n, !(accept && req_type) |=> (lr_q >= $past(lr_q)))
	// walk address never runs past the limit
	`TNCR_NEVER(a_cnt_range, clk, arst_n, (state_q == S_WALK1 || state_q == S_WALK2) && (cnt_q > lim_q))
	// a loaded result equals the new release floor
	`TNCR_ASSERT(a_out_load, clk, arst_n, fin_go |=> (out_valid_q && noisy_q == lr_q))

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Tree noise counter release unit testbench
// Drives release and restart requests under random idling on both channels.
// Each release is predicted by a bit-accurate model of the binary-tree counter
// and compared on arrival. Several noise scales are used, the extremes among
// them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import tncr_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 100;   // above the worst latency
	localparam int HOLD_CYCLES    = 400;
	localparam int IDLE_PCT       = 38;
	localparam int FRAC           = FRACTION_BITS_DEF;

	localparam bit REQ_RELEASE = 1'b0;
	localparam bit REQ_RESTART = 1'b1;

	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [OUT_W-1:0] OUT_SAT = {OUT_W{1'b1}};
	localparam logic [VALUE_W-1:0] VAL_MAX = {VALUE_W{1'b1}};

	// one row of the directed part; exp is only used when has_exp is set
	typedef struct packed {
		bit                 rt;
		bit [VALUE_W-1:0]   v;
		bit [NOISE_W-1:0]   n;
		bit                 has_exp;
		bit [OUT_W-1:0]     e;
	} dir_row_t;

	localparam int DIR_N = 16;
	dir_row_t dir_tab [DIR_N] = '{
		// first release after reset, scale 1.0, no noise: value comes out as is
		'{REQ_RELEASE, 44'd100,  24'd0,        1'b1, 47'd100},
		'{REQ_RELEASE, 44'd130,  24'd1000,     1'b0, 47'd0},
		'{REQ_RELEASE, 44'd131,  24'hFF0000,   1'b0, 47'd0},
		'{REQ_RELEASE, 44'd200,  24'd65536,    1'b0, 47'd0},
		'{REQ_RELEASE, 44'd210,  24'h800000,   1'b0, 47'd0},
		'{REQ_RELEASE, 44'd220,  24'h7FFFFF,   1'b0, 47'd0},
		'{REQ_RELEASE, 44'd5,    24'd0,        1'b0, 47'd0},
		'{REQ_RELEASE, 44'd400,  24'hABCDEF,   1'b0, 47'd0},
		// restart, then the largest value as the new base
		'{REQ_RESTART, 44'd0,    24'd0,        1'b0, 47'd0},
		'{REQ_RELEASE, VAL_MAX,  24'd0,        1'b1, {3'b000, VAL_MAX}},
		'{REQ_RELEASE, 44'd0,    24'd12345,    1'b0, 47'd0},
		// most negative noise on zero: candidate clamps to zero
		'{REQ_RESTART, VAL_MAX,  24'hFFFFFF,   1'b0, 47'd0},
		'{REQ_RELEASE, 44'd0,    24'h800000,   1'b1, 47'd0},
		// most positive noise on zero after restart: 127.99 truncates to 127
		'{REQ_RESTART, 44'd0,    24'd0,        1'b0, 47'd0},
		'{REQ_RELEASE, 44'd0,    24'h7FFFFF,   1'b1, 47'd127},
		'{REQ_RELEASE, 44'd1,    24'h000001,   1'b0, 47'd0}
	};

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [EPS_W-1:0]          cfg_wr_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      req_type;
	logic [VALUE_W-1:0]        raw_value;
	logic signed [NOISE_W-1:0] unit_noise_q16;
	logic                      out_valid;
	logic                      out_ready;
	logic [OUT_W-1:0]          noisy_value;

	tree_noise_counter_release_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.raw_value      (raw_value),
		.unit_noise_q16 (unit_noise_q16),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.noisy_value    (noisy_value)
	);

	// predictor state, a private copy of what the block keeps
	logic [EPS_W-1:0]         inv_eps;
	logic [31:0]              tree_index;
	logic [5:0]               top_len;
	logic [DATA_W-1:0]        base_true;
	logic signed [DATA_W-1:0] base_noisy;
	logic [DATA_W-1:0]        diff_true  [32];
	logic signed [DATA_W-1:0] diff_noisy [32];
	logic [OUT_W-1:0]         released_max;

	logic [OUT_W-1:0] release_q [$];   // noisy values still to arrive
	int  mismatches;
	int  failed;
	bit  no_idle;      // both sides run flat out while set
	bit  hold_req;     // asks the receiver for one long hold-off
	bit  typed_has;    // travels with the request: directed expectation
	logic [OUT_W-1:0] typed_val;

	function automatic logic signed [DATA_W-1:0] sat_add(
		input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
		logic signed [DATA_W:0] s;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s > $signed({1'b0, Q_MAX}))
			return Q_MAX;
		if (s < $signed({1'b1, Q_MIN}))
			return Q_MIN;
		return s[DATA_W-1:0];
	endfunction

	// integer difference into Q form, saturating
	function automatic logic signed [DATA_W-1:0] to_fixed(input logic signed [DATA_W-1:0] d);
		logic signed [DATA_W-1:0] lim;
		lim = Q_MAX >>> FRAC;
		if (d > lim)
			return Q_MAX;
		if (d < -lim - 1)
			return Q_MIN;
		return d <<< FRAC;
	endfunction

	// sign-magnitude product, truncated toward zero
	function automatic logic signed [DATA_W-1:0] scaled_noise(
		input logic [NOISE_W-1:0] unit, input logic [5:0] mult);
		logic [DATA_W-1:0] scale, mag, p;
		scale = DATA_W'(mult) * DATA_W'(inv_eps);
		mag   = unit[NOISE_W-1] ? (64'h1000000 - DATA_W'(unit)) : DATA_W'(unit);
		p     = (mag * scale) >> FRAC;
		return unit[NOISE_W-1] ? -$signed(p) : $signed(p);
	endfunction

	task automatic predict_release(input logic [VALUE_W-1:0] v,
		input logic [NOISE_W-1:0] n, output logic [OUT_W-1:0] r);
		logic [31:0]              idx;
		logic signed [DATA_W-1:0] vq;
		logic [DATA_W-1:0]        d, sum, cand;
		int                       lim, lsb, len;
		idx = tree_index + 1;
		tree_index = idx;
		if (idx != 0 && (idx & (idx - 1)) == 0) begin
			len = 0;
			while ((idx >> len) > 1)
				len++;
			top_len = len + 1;
			base_noisy = sat_add(base_noisy, to_fixed($signed(DATA_W'(v) - base_true)));
			base_noisy = sat_add(base_noisy, scaled_noise(n, 6'd1));
			base_true = DATA_W'(v);
			vq = base_noisy;
		end else begin
			lim = (top_len > 0) ? top_len - 1 : 0;
			if (lim > 32)
				lim = 32;
			lsb = -1;
			sum = 0;
			for (int i = 0; i < lim; i++)
				if (idx[i]) begin
					if (lsb < 0)
						lsb = i;
					else
						sum += diff_true[i];
				end
			if (lsb >= 0) begin
				d = DATA_W'(v) - base_true - sum;
				diff_true[lsb]  = d;
				diff_noisy[lsb] = sat_add(scaled_noise(n, 6'(lim)), to_fixed($signed(d)));
			end
			vq = base_noisy;
			for (int i = 0; i < lim; i++)
				if (idx[i])
					vq = sat_add(vq, diff_noisy[i]);
		end
		if (vq <= 0)
			cand = 0;
		else begin
			cand = DATA_W'(vq) >> FRAC;
			if (cand > DATA_W'(OUT_SAT))
				cand = DATA_W'(OUT_SAT);
		end
		if (cand[OUT_W-1:0] > released_max)
			released_max = cand[OUT_W-1:0];
		r = released_max;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// request side: every accepted request runs through the predictor
	always @(posedge clk) begin
		logic [OUT_W-1:0] r;
		if (arst_n && in_valid && in_ready) begin
			if (req_type == REQ_RESTART) begin
				// restart keeps the top length and the difference stores
				tree_index   = 0;
				base_true    = 0;
				base_noisy   = 0;
				released_max = 0;
			end else begin
				predict_release(raw_value, unit_noise_q16, r);
				release_q.push_back(typed_has ? typed_val : r);
			end
		end
	end

	// release side: compare against the oldest outstanding value
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (release_q.size() == 0) begin
				failed = 1;
				if (mismatches < 10)
					$display("unexpected release: got %0d", noisy_value);
				mismatches++;
			end else begin
				if (noisy_value !== release_q[0]) begin
					failed = 1;
					if (mismatches < 10)
						$display("noisy_value mismatch: exp %0d got %0d",
							release_q[0], noisy_value);
					mismatches++;
				end
				void'(release_q.pop_front());
			end
		end
	end

	// receiver: random back-pressure, one long hold-off on request
	initial begin
		int held;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				hold_req = 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				out_ready <= 1'b1;
			end else
				out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog: cycles without any handshake
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else if (++quiet >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send(input bit rt, input logic [VALUE_W-1:0] v,
		input logic [NOISE_W-1:0] n, input bit has, input logic [OUT_W-1:0] e);
		if (!no_idle)
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid       <= 1'b1;
		req_type       <= rt;
		raw_value      <= v;
		unit_noise_q16 <= n;
		typed_has      <= has;
		typed_val      <= e;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
	endtask

	// lets everything drain; a restart may still be in flight with nothing owed
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (release_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_scale(input logic [EPS_W-1:0] s);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= s;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		inv_eps = s;
		@(posedge clk);
	endtask

	task automatic random_phase(input int count, input int phase);
		logic [VALUE_W-1:0] cur;
		logic [NOISE_W-1:0] n;
		logic [VALUE_W-1:0] v;
		bit                 rt;
		cur = 0;
		for (int k = 0; k < count; k++) begin
			no_idle = (k >= count / 2 && k < count / 2 + 40);
			if (phase == 1 && k == 20)
				hold_req = 1'b1;             // block fills up behind the held result
			if (phase == 1 && k == 60) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (release_q.size() != 0)
					@(posedge clk);
			end
			rt = ($urandom_range(99) < 3) ? REQ_RESTART : REQ_RELEASE;
			// counters mostly climb; sometimes jump anywhere
			case ($urandom_range(9))
				0: v = {$urandom, $urandom};
				1: v = cur - $urandom_range(20);
				2: v = VAL_MAX - $urandom_range(3);
				default: v = cur + $urandom_range(50);
			endcase
			n = ($urandom_range(3) == 0) ? NOISE_W'($urandom)
				: NOISE_W'($signed($urandom_range(400000)) - 200000);
			if (rt == REQ_RESTART)
				cur = 0;
			else
				cur = v;
			send(rt, v, n, 1'b0, '0);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		logic [EPS_W-1:0] scales [5];
		scales = '{32'd0, 32'hFFFFFFFF, 32'd1, 32'd6553600, 32'd65536};
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		in_valid       = 1'b0;
		req_type       = REQ_RELEASE;
		raw_value      = '0;
		unit_noise_q16 = '0;
		typed_has      = 1'b0;
		typed_val      = '0;
		no_idle        = 1'b0;
		hold_req       = 1'b0;
		mismatches     = 0;
		failed         = 0;
		// reset state of the predictor
		inv_eps      = 32'd65536;
		tree_index   = 0;
		top_len      = 0;
		base_true    = 0;
		base_noisy   = 0;
		released_max = 0;
		for (int i = 0; i < 32; i++) begin
			diff_true[i]  = 0;
			diff_noisy[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, at the reset scale of 1.0
		for (int k = 0; k < DIR_N; k++)
			send(dir_tab[k].rt, dir_tab[k].v, dir_tab[k].n,
				dir_tab[k].has_exp, dir_tab[k].e);
		typed_has <= 1'b0;

		// random part, one scale per phase, each starting from a fresh sequence
		for (int p = 0; p < 5; p++) begin
			drain();
			set_scale(scales[p]);
			send(REQ_RESTART, '0, '0, 1'b0, '0);
			random_phase(160, p);
		end

		drain();
		if (failed == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
